[rtl/hrsbs_pkg.sv]
// Shared constants and types for the HTTP response status/body splitter.
package hrsbs_pkg;

	// Stream byte limit; bytes past it are ignored
	localparam int unsigned MaxBytes = 16383;
	localparam int unsigned CntW     = $clog2(MaxBytes + 1);
	localparam int unsigned LenW     = 14;
	localparam int unsigned MinLen   = 12;
	localparam int unsigned NumDigits = 3;

	// Characters of interest
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChZero  = 8'h30;

	// Progress through CR LF CR LF
	typedef enum logic [1:0] {
		SEP_NONE    = 2'd0,
		SEP_CR      = 2'd1,
		SEP_CRLF    = 2'd2,
		SEP_CRLFCR  = 2'd3
	} sep_t;

	typedef logic [CntW-1:0] cnt_t;

	// Parse state carried from byte to byte
	typedef struct packed {
		cnt_t        byte_count;
		logic        space_seen;
		logic [1:0]  digit_count;
		logic [15:0] code_acc;
		sep_t        sep;
		logic        in_body;
		cnt_t        body_count;
	} parse_t;

endpackage

[rtl/http_response_status_body_splitter_core.sv]
// Top level: byte-serial HTTP response status and body splitter.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one response byte per item in
//   rx_byte, with end_of_stream high on the last byte of a response.
//   Output channel (out_valid/out_ready) carries exactly one result item per
//   input item. body_valid/body_byte pass every byte after the first
//   CR LF CR LF, up to MaxBytes. On the item for the final byte, done_res
//   is high and status_error, resp_code, body_found and body_length report
//   on the whole response; the parser then starts over for the next stream.
//   The status code is the three bytes after the first space, weighted
//   100/10/1 after subtracting '0', with no digit check.
// Throughput: one item per cycle sustained while out_ready stays high. The
//   state update and the registered result are computed in one pass between
//   the accept edge and the result register; the result is valid next cycle.
// Reset: arst_n clears the parse state and the result valid flag at once.
// Stall: while a result waits and out_ready is low, in_ready drops and the
//   result holds; when out_ready is high a new item is taken in the same
//   cycle as the old result leaves.
module http_response_status_body_splitter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               end_of_stream,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               body_valid,
	output logic [7:0]         body_byte,
	output logic               done_res,
	output logic               status_error,
	output logic signed [15:0] resp_code,
	output logic               body_found,
	output logic [13:0]        body_length
);

	hrsbs_pkg::parse_t st_q;
	hrsbs_pkg::parse_t st_nxt;
	hrsbs_pkg::parse_t st_upd;

	logic               accept;
	logic               counted;
	logic               err;
	logic [15:0]        acc_x10;
	logic [15:0]        digit_val;

	logic               out_valid_q;
	logic               body_valid_q;
	logic [7:0]         body_byte_q;
	logic               done_q;
	logic               err_q;
	logic [15:0]        code_q;
	logic               found_q;
	logic [13:0]        len_q;

	logic               body_valid_d;
	logic [7:0]         body_byte_d;

	// Take a new item whenever the result slot is empty or draining
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign counted   = st_q.byte_count < hrsbs_pkg::CntW'(hrsbs_pkg::MaxBytes);
	assign acc_x10   = (st_q.code_acc << 3) + (st_q.code_acc << 1);
	assign digit_val = {8'd0, rx_byte} - {8'd0, hrsbs_pkg::ChZero};

	// Advance the parse state for one byte
	always_comb begin
		st_upd       = st_q;
		body_valid_d = 1'b0;
		body_byte_d  = 8'd0;
		if (counted) begin
			st_upd.byte_count = st_q.byte_count + 1'b1;
			if (!st_q.space_seen) begin
				if (rx_byte == hrsbs_pkg::ChSpace) begin
					st_upd.space_seen = 1'b1;
				end
			end else if (st_q.digit_count < 2'(hrsbs_pkg::NumDigits)) begin
				st_upd.code_acc    = acc_x10 + digit_val;
				st_upd.digit_count = st_q.digit_count + 2'd1;
			end

			if (st_q.in_body) begin
				body_valid_d      = 1'b1;
				body_byte_d       = rx_byte;
				st_upd.body_count = st_q.body_count + 1'b1;
			end else if (rx_byte == hrsbs_pkg::ChCr) begin
				st_upd.sep = (st_q.sep == hrsbs_pkg::SEP_CRLF) ?
					hrsbs_pkg::SEP_CRLFCR : hrsbs_pkg::SEP_CR;
			end else if (rx_byte == hrsbs_pkg::ChLf) begin
				unique case (st_q.sep)
					hrsbs_pkg::SEP_CR: begin
						st_upd.sep = hrsbs_pkg::SEP_CRLF;
					end
					hrsbs_pkg::SEP_CRLFCR: begin
						st_upd.sep     = hrsbs_pkg::SEP_NONE;
						st_upd.in_body = 1'b1;
					end
					default: begin
						st_upd.sep = hrsbs_pkg::SEP_NONE;
					end
				endcase
			end else begin
				st_upd.sep = hrsbs_pkg::SEP_NONE;
			end
		end
	end

	assign err = (st_upd.byte_count < hrsbs_pkg::CntW'(hrsbs_pkg::MinLen)) ||
		(st_upd.digit_count < 2'(hrsbs_pkg::NumDigits));

	// Drop back to the reset state after the final byte
	always_comb begin
		st_nxt = st_upd;
		if (end_of_stream) begin
			st_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				st_q <= st_nxt;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	// Result register; hold while the receiver stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			body_valid_q <= body_valid_d;
			body_byte_q  <= body_byte_d;
			done_q       <= end_of_stream;
			err_q        <= end_of_stream && err;
			code_q       <= (end_of_stream && !err) ? st_upd.code_acc : 16'd0;
			found_q      <= end_of_stream && st_upd.in_body &&
				(st_upd.body_count != '0);
			len_q        <= end_of_stream ? st_upd.body_count[13:0] : 14'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign body_valid   = body_valid_q;
	assign body_byte    = body_byte_q;
	assign done_res     = done_q;
	assign status_error = err_q;
	assign resp_code    = signed'(code_q);
	assign body_found   = found_q;
	assign body_length  = len_q;

endmodule

[rtl/hrsbs_checker.sv]
// Port-level checker for the splitter, bound to the top level.
module hrsbs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               body_valid,
	input logic [7:0]         body_byte,
	input logic               done_res,
	input logic               status_error,
	input logic signed [15:0] resp_code,
	input logic               body_found,
	input logic [13:0]        body_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(body_byte) &&
			$stable(done_res))
		else $error("result dropped or changed under stall");

	a_no_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> !status_error && resp_code == 16'sd0 &&
			!body_found && body_length == 14'd0)
		else $error("summary fields set on a non-final item");

	a_body_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !body_valid |-> body_byte == 8'd0)
		else $error("body byte set without body_valid");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_error |-> resp_code == 16'sd0)
		else $error("status code set on an error status");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && body_found |-> body_length != 14'd0 || done_res)
		else $error("body found with no length");

endmodule

bind http_response_status_body_splitter_core hrsbs_checker u_hrsbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.body_valid   (body_valid),
	.body_byte    (body_byte),
	.done_res     (done_res),
	.status_error (status_error),
	.resp_code    (resp_code),
	.body_found   (body_found),
	.body_length  (body_length)
);
